FILE: rtl/lfcp_pkg.sv
// Shared types and constants for the LED frame CRC-16 packer.
package lfcp_pkg;

  localparam int unsigned NumChannelsDef = 7;
  localparam int unsigned LevelW         = 16;
  localparam int unsigned ByteW          = 8;

  // One classified channel level, handed from the front end to the byte sequencer
  typedef struct packed {
    logic              last;   // closes the frame
    logic [LevelW-1:0] level;
  } lfcp_entry_t;

  // Byte sequencer phases
  typedef enum logic [2:0] {
    PH_LO,
    PH_HI,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_STATUS
  } lfcp_phase_e;

endpackage

FILE: rtl/lfcp_front.sv
// Input front end: takes channel levels and tags the last channel of each frame.
module lfcp_front #(
  parameter int unsigned NUM_CHANNELS = lfcp_pkg::NumChannelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [lfcp_pkg::LevelW-1:0]  level_i,
  input  logic                         full_i,
  output logic                         push_o,
  output lfcp_pkg::lfcp_entry_t        entry_o
);
  import lfcp_pkg::*;

  localparam int unsigned CntW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_CHANNELS - 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last;

  assign s_axis_tready_o = ~full_i;
  assign push_o          = s_axis_tvalid_i & ~full_i;

  // saturating close: any count at or past the last channel ends the frame
  assign last = (cnt_q >= LastCnt);

  assign entry_o.level = level_i;
  assign entry_o.last  = last;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/lfcp_fifo.sv
// Two-entry queue between the front end and the byte sequencer.
module lfcp_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lfcp_pkg::lfcp_entry_t  entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output lfcp_pkg::lfcp_entry_t  entry_o
);
  import lfcp_pkg::*;

  lfcp_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/lfcp_back.sv
// Byte sequencer: emits level bytes, folds the CRC and closes frames.
module lfcp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  lfcp_pkg::lfcp_entry_t       entry_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lfcp_pkg::ByteW-1:0]  m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);
  import lfcp_pkg::*;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcSeed = 16'hFFFF;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  lfcp_phase_e      ph_q, ph_d;
  logic [15:0]      crc_q, crc_d;
  logic             out_free, adv;
  logic [ByteW-1:0] byte_d;
  logic             end_d;
  logic             m_valid_q;
  logic [ByteW-1:0] m_data_q;
  logic             m_last_q;

  // output register frees up when its word is taken
  assign out_free = ~m_valid_q | m_axis_tready_i;
  assign adv      = valid_i & out_free;

  // next phase
  always_comb begin
    ph_d = ph_q;
    if (adv) begin
      unique case (ph_q)
        PH_LO:     ph_d = PH_HI;
        PH_HI:     ph_d = entry_i.last ? PH_CRC_LO : PH_LO;
        PH_CRC_LO: ph_d = PH_CRC_HI;
        PH_CRC_HI: ph_d = PH_STATUS;
        PH_STATUS: ph_d = PH_LO;
        default:   ph_d = PH_LO;
      endcase
    end
  end

  // byte selection, CRC update and queue pop
  always_comb begin
    byte_d = '0;
    end_d  = 1'b0;
    pop_o  = 1'b0;
    crc_d  = crc_q;
    unique case (ph_q)
      PH_LO: begin
        byte_d = entry_i.level[7:0];
        if (adv) crc_d = crc_fold(crc_q, entry_i.level[7:0]);
      end
      PH_HI: begin
        byte_d = entry_i.level[15:8];
        if (adv) crc_d = crc_fold(crc_q, entry_i.level[15:8]);
        pop_o  = adv & ~entry_i.last;
      end
      PH_CRC_LO: byte_d = crc_q[7:0];
      PH_CRC_HI: byte_d = crc_q[15:8];
      PH_STATUS: begin
        end_d = 1'b1;
        pop_o = adv;
        if (adv) crc_d = CrcSeed;
      end
      default: byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_LO;
      crc_q     <= CrcSeed;
      m_valid_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      crc_q <= crc_d;
      if (out_free) begin
        m_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= byte_d;
      m_last_q <= end_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

FILE: rtl/led_frame_crc16_packer_core.sv
// LED frame packer top level: channel levels in, CRC-16 protected byte frame out.
// Each 16-bit level word on the slave side becomes two bytes on the master side,
// low byte first; after every NUM_CHANNELS levels the frame closes with the CRC-16
// (Modbus: reflected, polynomial 0xA001, seed 0xFFFF) low and high bytes and a zero
// status byte flagged by tlast, then the CRC and channel count start afresh. The
// output carries one byte per cycle while the receiver is ready, so a level gives two
// bytes and the closing level of a frame five; the sustained input rate is set by the
// single byte-wide output register. A two-entry queue sits between input and
// sequencer, so input stays ready while the output stalls until the queue fills.
// A level accepted at the input passes through the queue and then the output
// register before its first byte is valid.
module led_frame_crc16_packer_core #(
  parameter int unsigned NUM_CHANNELS = lfcp_pkg::NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] level
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] frame_byte
  output logic        m_axis_tlast_o    // frame_end
);
  import lfcp_pkg::*;

  lfcp_entry_t push_entry, pop_entry;
  logic        push, full, pop, q_valid;

  lfcp_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .level_i         (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  lfcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  lfcp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: bench/led_frame_crc16_packer_core_tb.sv
// Self-checking bench for the LED frame CRC-16 packer: stream levels in, check framed bytes.
`timescale 1ns / 100ps

module led_frame_crc16_packer_core_tb;

  import lfcp_pkg::*;

  localparam int unsigned NumChannels = NumChannelsDef;
  localparam int unsigned NumLevels   = 160;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 20;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [15:0] CrcSeed     = 16'hFFFF;
  localparam logic [7:0]  StatusOk    = 8'h00;

  // receiver back-pressure patterns
  localparam int unsigned RxAlways  = 0;
  localparam int unsigned RxCoin    = 1;
  localparam int unsigned RxSparse  = 2;
  localparam int unsigned RxPeriod  = 3;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_byte_t;

  // Tracks the frame the block should be building and the bytes still owed.
  class led_frame_tracker;
    logic [15:0]  crc;
    int unsigned  chan_cnt;
    frame_byte_t  pending_bytes[$];
    int unsigned  errors;
    int unsigned  levels_taken;
    int unsigned  bytes_seen;
    int unsigned  frames_closed;

    function new();
      crc           = CrcSeed;
      chan_cnt      = 0;
      errors        = 0;
      levels_taken  = 0;
      bytes_seen    = 0;
      frames_closed = 0;
    endfunction

    function logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
    endfunction

    function void push_byte(logic [7:0] d, logic l);
      frame_byte_t fb;
      fb.data = d;
      fb.last = l;
      pending_bytes.push_back(fb);
    endfunction

    function void take_level(logic [LevelW-1:0] lvl);
      levels_taken++;
      push_byte(lvl[7:0], 1'b0);
      push_byte(lvl[15:8], 1'b0);
      crc = crc16_fold(crc, lvl[7:0]);
      crc = crc16_fold(crc, lvl[15:8]);
      // saturating close: any count at or past the last channel ends the frame
      if (chan_cnt + 1 >= NumChannels) begin
        push_byte(crc[7:0], 1'b0);
        push_byte(crc[15:8], 1'b0);
        push_byte(StatusOk, 1'b1);
        crc      = CrcSeed;
        chan_cnt = 0;
      end else begin
        chan_cnt++;
      end
    endfunction

    function void match_byte(logic [7:0] d, logic l);
      frame_byte_t want;
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got data %02h last %0b", $time, d, l);
        return;
      end
      want = pending_bytes.pop_front();
      if (d !== want.data) begin
        errors++;
        $display("%0t: data mismatch: expected %02h, got %02h", $time, want.data, d);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: tlast mismatch: expected %0b, got %0b", $time, want.last, l);
      end
      if (want.last && l === 1'b1) frames_closed++;
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [LevelW-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [ByteW-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  led_frame_tracker tracker = new();
  bit               hold_req = 1'b0;
  int unsigned      cycles = 0;

  always #2 clk_i = ~clk_i;

  led_frame_crc16_packer_core #(
    .NUM_CHANNELS(NumChannels)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  // offer one level from the next falling edge until it is taken
  task automatic send_level(logic [LevelW-1:0] lvl);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lvl;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_level(lvl);
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= LevelW'($urandom());
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LevelW-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 16'h1 << $urandom_range(0, 15);
      3:       return ~(16'h1 << $urandom_range(0, 15));
      default: return LevelW'($urandom());
    endcase
  endfunction

  // sender: directed frames, then bursts of random levels
  initial begin
    logic [LevelW-1:0] directed[$];
    int unsigned       sent;
    int unsigned       burst;
    bit                held;
    bit                paused;
    directed = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0001,
                 16'h8000, 16'h1234, 16'hFEDC, 16'h0100, 16'h0080, 16'h7FFF, 16'h8001};
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) send_level(directed[i]);
    idle_sender(1);
    wait_drained();
    while (sent < NumLevels) begin
      burst = $urandom_range(1, 12);
      if (!held && sent >= 60) begin
        // receiver goes quiet while a long burst keeps coming
        held     = 1'b1;
        hold_req = 1'b1;
        burst    = 14;
      end
      repeat (burst) begin
        send_level(pick_level());
        sent++;
      end
      if (!paused && sent >= 110) begin
        paused = 1'b1;
        idle_sender(1);
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 6));
      end
    end
    idle_sender(1);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d levels, %0d bytes, %0d closed frames of %0d channels,",
             tracker.levels_taken, tracker.bytes_seen, tracker.frames_closed, NumChannels);
    $display("with bursty input, varied output stalls and one long output hold-off.");
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: back-pressure switches among randomly chosen patterns
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned rx_mode;
    int unsigned phase;
    hold_left = 0;
    mode_left = 0;
    rx_mode   = RxAlways;
    phase     = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(RxAlways, RxPeriod);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (rx_mode)
          RxAlways: m_axis_tready <= 1'b1;
          RxCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
          RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:  m_axis_tready <= (phase % 5 != 0) && (phase % 7 != 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.match_byte(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycles, tracker.pending());
      $display("FAILURE");
      $finish;
    end
  end

endmodule
